@@ rtl/core/rphr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rphr_pkg
// Shared widths, field offsets, types and helpers of the ray / plane hit unit.
// ----------------------------------------------------------------------------
package rphr_pkg;

    // component format
    localparam int CW = 20;
    localparam int FB = 10;
    localparam int VW = 3 * CW;
    localparam int DW = 31;
    localparam int MW = 10;
    localparam logic [MW-1:0] MARGIN_RST = MW'(102);

    // stream layout
    localparam int IN_RAW_W     = 5 * VW + CW + DW;
    localparam int IN_TDATA_W   = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_RAW_W    = DW + 2 * VW;
    localparam int OUT_TDATA_W  = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OFS_START    = 0;
    localparam int OFS_DIR      = VW;
    localparam int OFS_NORMAL   = 2 * VW;
    localparam int OFS_OFFSET   = 3 * VW;
    localparam int OFS_CENTER   = 3 * VW + CW;
    localparam int OFS_HALF     = 4 * VW + CW;
    localparam int OFS_BEST     = 5 * VW + CW;
    localparam int OFS_NSTART   = DW;
    localparam int OFS_NDIR     = DW + VW;

    // intersection datapath
    localparam int PROD_W = 2 * CW;
    localparam int DOT_W  = 2 * CW + 2;
    localparam int DIST_W = 2 * CW;
    localparam int NUM_W  = DIST_W + FB;
    localparam int DEN_W  = 2 * CW;
    localparam int Q_W    = DW;
    localparam int TDX_W  = DEN_W + Q_W;
    localparam int TD_W   = Q_W + 1 + CW;
    localparam int P_W    = TD_W - FB + 1;
    localparam int BND_W  = CW + 2;

    // reflection and normalization
    localparam int K_W      = DEN_W - FB + 1;
    localparam int KN_W     = K_W + 1 + CW;
    localparam int R_W      = KN_W - (FB - 1) + 1;
    localparam int MAG_W    = R_W;
    localparam int LEAD_W   = $clog2(MAG_W);
    localparam int NM_W     = 30;
    localparam int NORM_TOP = NM_W - 1;
    localparam int SQ_W     = 2 * NM_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int LEN_W    = SUM_W / 2;
    localparam int SQ_STEPS = SUM_W / 2;
    localparam int RES_W    = SUM_W + 1;
    localparam int NQ_W     = FB + 1;
    localparam int DV_W     = LEN_W + NQ_W;

    localparam longint EPS_RAW = ((64'sd1 <<< (2 * FB)) + 64'sd50000) / 64'sd100000;
    localparam longint EPS_Q   = (EPS_RAW > 0) ? EPS_RAW : 64'sd1;
    localparam logic signed [DOT_W-1:0] NEG_EPS = DOT_W'(-EPS_Q);

    typedef logic [2:0][CW-1:0]  vec_t;
    typedef logic [2:0][R_W-1:0] rvec_t;

    typedef struct packed {
        logic          func;
        logic [DW-1:0] best;
        vec_t          s;
        vec_t          d;
        vec_t          n;
        vec_t          c;
        vec_t          h;
    } item_t;

    typedef struct packed {
        logic          rej;
        logic          func;
        logic [DW-1:0] best;
        vec_t          s;
        vec_t          d;
        vec_t          c;
        vec_t          h;
        rvec_t         r;
    } tside_t;

    typedef struct packed {
        logic          hit;
        logic          refl;
        logic [DW-1:0] bdist;
        vec_t          p;
    } nside_t;

    // clamp a wide signed value to the component range
    function automatic logic [CW-1:0] sat_comp(input logic signed [P_W-1:0] v);
        logic [CW-1:0] res;
        if (v[P_W-1:CW-1] == '0 || v[P_W-1:CW-1] == '1) begin
            res = v[CW-1:0];
        end else if (v[P_W-1]) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res = {1'b0, {(CW-1){1'b1}}};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/rphr_tdiv.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rphr_tdiv
// Pipelined restoring divider for the ray parameter, one quotient bit a stage,
// with an overflow flag for quotients beyond the distance range.
// ----------------------------------------------------------------------------
module rphr_tdiv import rphr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             vld_in,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  tside_t           side_in,
    output logic             vld_out,
    output logic [Q_W-1:0]   quot,
    output logic             ovf,
    output tside_t           side_out
);

    logic             vld_reg  [0:Q_W];
    logic [NUM_W-1:0] rem_reg  [0:Q_W];
    logic [DEN_W-1:0] den_reg  [0:Q_W];
    logic [Q_W-1:0]   quo_reg  [0:Q_W];
    logic             ovf_reg  [0:Q_W];
    tside_t           side_reg [0:Q_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= num;
            den_reg[0]  <= den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= TDX_W'(num) >= {den, {Q_W{1'b0}}};
            side_reg[0] <= side_in;
        end
    end

    for (genvar j = 1; j <= Q_W; j++) begin : g_step
        localparam int B = Q_W - j;
        logic [TDX_W-1:0] trial;
        logic             take;
        logic [NUM_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        always_comb begin
            trial    = TDX_W'(den_reg[j-1]) << B;
            take     = TDX_W'(rem_reg[j-1]) >= trial;
            rem_next = take ? rem_reg[j-1] - trial[NUM_W-1:0] : rem_reg[j-1];
            quo_next = quo_reg[j-1];
            quo_next[B] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (en) begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_reg[j-1];
                quo_reg[j]  <= quo_next;
                ovf_reg[j]  <= ovf_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign vld_out  = vld_reg[Q_W];
    assign quot     = quo_reg[Q_W];
    assign ovf      = ovf_reg[Q_W];
    assign side_out = side_reg[Q_W];

endmodule
`default_nettype wire

@@ rtl/core/rphr_norm.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rphr_norm
// Reflected direction normalizer: scale, sum of squares, pipelined square
// root and three pipelined dividers, one result bit a stage.
// ----------------------------------------------------------------------------
module rphr_norm import rphr_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   vld_in,
    input  rvec_t  r,
    input  nside_t side_in,
    output logic   vld_out,
    output vec_t   dir,
    output nside_t side_out
);

    // magnitudes and largest one
    logic             n1_vld_reg;
    logic [MAG_W-1:0] n1_mag_reg [3];
    logic [2:0]       n1_sgn_reg;
    logic [MAG_W-1:0] n1_max_reg;
    nside_t           n1_side_reg;
    logic [MAG_W-1:0] mag_next [3];
    logic [MAG_W-1:0] max_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = r[i][R_W-1] ? MAG_W'(-$signed(r[i])) : MAG_W'(r[i]);
        end
        max_next = mag_next[0];
        if (mag_next[1] > max_next) max_next = mag_next[1];
        if (mag_next[2] > max_next) max_next = mag_next[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n1_vld_reg <= 1'b0;
        end else if (en) begin
            n1_vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n1_mag_reg[i] <= mag_next[i];
                n1_sgn_reg[i] <= r[i][R_W-1];
            end
            n1_max_reg  <= max_next;
            n1_side_reg <= side_in;
        end
    end

    // leading one
    logic              n2_vld_reg;
    logic [MAG_W-1:0]  n2_mag_reg [3];
    logic [2:0]        n2_sgn_reg;
    logic [LEAD_W-1:0] n2_lead_reg;
    logic              n2_zero_reg;
    nside_t            n2_side_reg;
    logic [LEAD_W-1:0] lead_next;

    always_comb begin
        lead_next = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (n1_max_reg[i]) lead_next = LEAD_W'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n2_vld_reg <= 1'b0;
        end else if (en) begin
            n2_vld_reg <= n1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n2_mag_reg  <= n1_mag_reg;
            n2_sgn_reg  <= n1_sgn_reg;
            n2_lead_reg <= lead_next;
            n2_zero_reg <= (n1_max_reg == '0);
            n2_side_reg <= n1_side_reg;
        end
    end

    // scale so that the leading one of the largest magnitude sits at the top bit
    logic            n3_vld_reg;
    logic [NM_W-1:0] n3_sm_reg [3];
    logic [2:0]      n3_sgn_reg;
    logic            n3_zero_reg;
    nside_t          n3_side_reg;
    logic [NM_W-1:0] sm_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (n2_lead_reg > LEAD_W'(NORM_TOP)) begin
                sm_next[i] = NM_W'(n2_mag_reg[i] >> (n2_lead_reg - LEAD_W'(NORM_TOP)));
            end else begin
                sm_next[i] = NM_W'(n2_mag_reg[i] << (LEAD_W'(NORM_TOP) - n2_lead_reg));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n3_vld_reg <= 1'b0;
        end else if (en) begin
            n3_vld_reg <= n2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_sm_reg   <= sm_next;
            n3_sgn_reg  <= n2_sgn_reg;
            n3_zero_reg <= n2_zero_reg;
            n3_side_reg <= n2_side_reg;
        end
    end

    // squares
    logic            n4_vld_reg;
    logic [SQ_W-1:0] n4_sq_reg [3];
    logic [NM_W-1:0] n4_sm_reg [3];
    logic [2:0]      n4_sgn_reg;
    logic            n4_zero_reg;
    nside_t          n4_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n4_vld_reg <= 1'b0;
        end else if (en) begin
            n4_vld_reg <= n3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n4_sq_reg[i] <= n3_sm_reg[i] * n3_sm_reg[i];
            end
            n4_sm_reg   <= n3_sm_reg;
            n4_sgn_reg  <= n3_sgn_reg;
            n4_zero_reg <= n3_zero_reg;
            n4_side_reg <= n3_side_reg;
        end
    end

    // square root, one root bit a stage; entry 0 holds the sum
    logic             sq_vld_reg  [0:SQ_STEPS];
    logic [RES_W-1:0] sq_n_reg    [0:SQ_STEPS];
    logic [RES_W-1:0] sq_res_reg  [0:SQ_STEPS];
    logic [NM_W-1:0]  sq_sm_reg   [0:SQ_STEPS][3];
    logic [2:0]       sq_sgn_reg  [0:SQ_STEPS];
    logic             sq_zero_reg [0:SQ_STEPS];
    nside_t           sq_side_reg [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg[0] <= 1'b0;
        end else if (en) begin
            sq_vld_reg[0] <= n4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_n_reg[0]    <= RES_W'(n4_sq_reg[0]) + RES_W'(n4_sq_reg[1])
                            + RES_W'(n4_sq_reg[2]);
            sq_res_reg[0]  <= '0;
            sq_sm_reg[0]   <= n4_sm_reg;
            sq_sgn_reg[0]  <= n4_sgn_reg;
            sq_zero_reg[0] <= n4_zero_reg;
            sq_side_reg[0] <= n4_side_reg;
        end
    end

    for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
        localparam int E = 2 * (SQ_STEPS - j);
        logic [RES_W-1:0] bit_val;
        logic [RES_W-1:0] trial;
        logic [RES_W-1:0] n_next;
        logic [RES_W-1:0] res_next;

        always_comb begin
            bit_val = RES_W'(1) << E;
            trial   = sq_res_reg[j-1] + bit_val;
            if (sq_n_reg[j-1] >= trial) begin
                n_next   = sq_n_reg[j-1] - trial;
                res_next = (sq_res_reg[j-1] >> 1) + bit_val;
            end else begin
                n_next   = sq_n_reg[j-1];
                res_next = sq_res_reg[j-1] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[j] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[j] <= sq_vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_n_reg[j]    <= n_next;
                sq_res_reg[j]  <= res_next;
                sq_sm_reg[j]   <= sq_sm_reg[j-1];
                sq_sgn_reg[j]  <= sq_sgn_reg[j-1];
                sq_zero_reg[j] <= sq_zero_reg[j-1];
                sq_side_reg[j] <= sq_side_reg[j-1];
            end
        end
    end

    // rounded divide of each scaled magnitude by the length
    logic             dv_vld_reg  [0:NQ_W];
    logic [DV_W-1:0]  dv_rem_reg  [0:NQ_W][3];
    logic [NQ_W-1:0]  dv_quo_reg  [0:NQ_W][3];
    logic [LEN_W-1:0] dv_len_reg  [0:NQ_W];
    logic [2:0]       dv_sgn_reg  [0:NQ_W];
    logic             dv_zero_reg [0:NQ_W];
    nside_t           dv_side_reg [0:NQ_W];
    logic [LEN_W-1:0] len;

    assign len = sq_res_reg[SQ_STEPS][LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= sq_vld_reg[SQ_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dv_rem_reg[0][i] <= DV_W'({sq_sm_reg[SQ_STEPS][i], {FB{1'b0}}})
                                  + DV_W'(len >> 1);
                dv_quo_reg[0][i] <= '0;
            end
            dv_len_reg[0]  <= len;
            dv_sgn_reg[0]  <= sq_sgn_reg[SQ_STEPS];
            dv_zero_reg[0] <= sq_zero_reg[SQ_STEPS];
            dv_side_reg[0] <= sq_side_reg[SQ_STEPS];
        end
    end

    for (genvar j = 1; j <= NQ_W; j++) begin : g_div
        localparam int B = NQ_W - j;
        logic [DV_W-1:0] trial;
        logic [DV_W-1:0] rem_next [3];
        logic [NQ_W-1:0] quo_next [3];

        always_comb begin
            trial = DV_W'(dv_len_reg[j-1]) << B;
            for (int i = 0; i < 3; i++) begin
                quo_next[i] = dv_quo_reg[j-1][i];
                if (dv_rem_reg[j-1][i] >= trial) begin
                    rem_next[i]    = dv_rem_reg[j-1][i] - trial;
                    quo_next[i][B] = 1'b1;
                end else begin
                    rem_next[i] = dv_rem_reg[j-1][i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[j] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[j] <= dv_vld_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[j]  <= rem_next;
                dv_quo_reg[j]  <= quo_next;
                dv_len_reg[j]  <= dv_len_reg[j-1];
                dv_sgn_reg[j]  <= dv_sgn_reg[j-1];
                dv_zero_reg[j] <= dv_zero_reg[j-1];
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (dv_zero_reg[NQ_W]) begin
                dir[i] = '0;
            end else if (dv_sgn_reg[NQ_W][i]) begin
                dir[i] = CW'(-$signed({1'b0, dv_quo_reg[NQ_W][i]}));
            end else begin
                dir[i] = CW'(dv_quo_reg[NQ_W][i]);
            end
        end
    end

    assign vld_out  = dv_vld_reg[NQ_W];
    assign side_out = dv_side_reg[NQ_W];

endmodule
`default_nettype wire

@@ rtl/core/ray_plane_hit_reflect_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ray_plane_hit_reflect_unit
// Ray against bounded plane test in signed Q9.10, giving the nearer hit
// distance, the hit point and the normalized reflected direction.
//
//   channel  ports                 content
//   input    s_tvalid/s_tready     ray, plane, best distance; s_tuser = func
//   result   m_tvalid/m_tready     distance, hit point, direction; m_tuser flags
//   config   cfg_wr_en/cfg_wr_data bounds margin, Q0.10
//
// one transfer accepted per cycle while the result side is not stalled
// the ray parameter divider, the square root and the direction
// dividers are pipelined, each one result bit per stage
// synchronous active-low reset clears valid bits and restores the margin
// a stalled result freezes the whole pipeline, nothing is dropped or repeated
// ----------------------------------------------------------------------------
module ray_plane_hit_reflect_unit import rphr_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // ray_start, ray_dir, plane_normal, plane_offset, plane_center,
    // plane_half_size, best_distance_in
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // func
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // best_distance_out, next_start, next_dir
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // hit, reflected
    output logic [1:0]             m_tuser,
    input  logic                   cfg_wr_en,
    input  logic [MW-1:0]          cfg_wr_data
);

    logic          en;
    logic [MW-1:0] margin_reg;

    logic                   m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic [1:0]             m_user_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= MARGIN_RST;
        end else if (cfg_wr_en) begin
            margin_reg <= cfg_wr_data;
        end
    end

    // stage a: unpack and dot product terms
    item_t                     in_item;
    logic                      a_vld_reg;
    item_t                     a_item_reg;
    logic [CW-1:0]             a_off_reg;
    logic signed [PROD_W-1:0]  a_nd_reg [3];
    logic signed [PROD_W-1:0]  a_ns_reg [3];

    always_comb begin
        in_item.func = s_tuser;
        in_item.best = s_tdata[OFS_BEST +: DW];
        in_item.s    = s_tdata[OFS_START +: VW];
        in_item.d    = s_tdata[OFS_DIR +: VW];
        in_item.n    = s_tdata[OFS_NORMAL +: VW];
        in_item.c    = s_tdata[OFS_CENTER +: VW];
        in_item.h    = s_tdata[OFS_HALF +: VW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg <= in_item;
            a_off_reg  <= s_tdata[OFS_OFFSET +: CW];
            for (int i = 0; i < 3; i++) begin
                a_nd_reg[i] <= $signed(in_item.n[i]) * $signed(in_item.d[i]);
                a_ns_reg[i] <= $signed(in_item.n[i]) * $signed(in_item.s[i]);
            end
        end
    end

    // stage b: dot products and signed distance
    logic                     b_vld_reg;
    item_t                    b_item_reg;
    logic signed [DOT_W-1:0]  b_d1_reg;
    logic signed [DOT_W-1:0]  b_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_item_reg <= a_item_reg;
            b_d1_reg   <= DOT_W'(a_nd_reg[0]) + DOT_W'(a_nd_reg[1]) + DOT_W'(a_nd_reg[2]);
            b_dist_reg <= DOT_W'(a_ns_reg[0]) + DOT_W'(a_ns_reg[1]) + DOT_W'(a_ns_reg[2])
                        - (DOT_W'($signed(a_off_reg)) <<< FB);
        end
    end

    // stage c: facing and behind tests, divider operands, reflection scale
    logic              c_vld_reg;
    item_t             c_item_reg;
    logic              c_rej_reg;
    logic [NUM_W-1:0]  c_num_reg;
    logic [DEN_W-1:0]  c_den_reg;
    logic [K_W-1:0]    c_k_reg;
    logic [DEN_W-1:0]  negd1;
    logic [DEN_W:0]    ksum;

    assign negd1 = DEN_W'(-b_d1_reg);
    assign ksum  = {1'b0, negd1} + (DEN_W+1)'(1 << (FB - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_item_reg <= b_item_reg;
            c_rej_reg  <= (b_d1_reg > NEG_EPS) || b_dist_reg[DOT_W-1];
            c_num_reg  <= {b_dist_reg[DIST_W-1:0], {FB{1'b0}}};
            c_den_reg  <= negd1;
            c_k_reg    <= ksum[DEN_W:FB];
        end
    end

    // stage d: reflection products
    logic                    d_vld_reg;
    item_t                   d_item_reg;
    logic                    d_rej_reg;
    logic [NUM_W-1:0]        d_num_reg;
    logic [DEN_W-1:0]        d_den_reg;
    logic signed [KN_W-1:0]  d_kn_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld_reg <= 1'b0;
        end else if (en) begin
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_item_reg <= c_item_reg;
            d_rej_reg  <= c_rej_reg;
            d_num_reg  <= c_num_reg;
            d_den_reg  <= c_den_reg;
            for (int i = 0; i < 3; i++) begin
                d_kn_reg[i] <= $signed({1'b0, c_k_reg}) * $signed(c_item_reg.n[i]);
            end
        end
    end

    // stage e: reflected direction
    logic                    e_vld_reg;
    tside_t                  e_side_reg;
    logic [NUM_W-1:0]        e_num_reg;
    logic [DEN_W-1:0]        e_den_reg;
    logic signed [KN_W-1:0]  kn_rnd [3];
    rvec_t                   r_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            kn_rnd[i] = (d_kn_reg[i] + KN_W'(1 << (FB - 2))) >>> (FB - 1);
            r_next[i] = R_W'($signed(kn_rnd[i][KN_W-FB:0]))
                      + R_W'($signed(d_item_reg.d[i]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (en) begin
            e_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_side_reg.rej  <= d_rej_reg;
            e_side_reg.func <= d_item_reg.func;
            e_side_reg.best <= d_item_reg.best;
            e_side_reg.s    <= d_item_reg.s;
            e_side_reg.d    <= d_item_reg.d;
            e_side_reg.c    <= d_item_reg.c;
            e_side_reg.h    <= d_item_reg.h;
            e_side_reg.r    <= r_next;
            e_num_reg       <= d_num_reg;
            e_den_reg       <= d_den_reg;
        end
    end

    // ray parameter
    logic           td_vld;
    logic [Q_W-1:0] td_t;
    logic           td_ovf;
    tside_t         td_side;

    rphr_tdiv u_tdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (e_vld_reg),
        .num      (e_num_reg),
        .den      (e_den_reg),
        .side_in  (e_side_reg),
        .vld_out  (td_vld),
        .quot     (td_t),
        .ovf      (td_ovf),
        .side_out (td_side)
    );

    // stage f: nearer test and step along the ray
    logic                    f_vld_reg;
    tside_t                  f_side_reg;
    logic [Q_W-1:0]          f_t_reg;
    logic                    f_hitpre_reg;
    logic signed [TD_W-1:0]  f_td_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_vld_reg <= 1'b0;
        end else if (en) begin
            f_vld_reg <= td_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_side_reg   <= td_side;
            f_t_reg      <= td_t;
            f_hitpre_reg <= !td_side.rej && !td_ovf && (td_t < td_side.best);
            for (int i = 0; i < 3; i++) begin
                f_td_reg[i] <= $signed({1'b0, td_t}) * $signed(td_side.d[i]);
            end
        end
    end

    // stage g: hit point and widened box
    logic                     g_vld_reg;
    logic                     g_hitpre_reg;
    logic [Q_W-1:0]           g_t_reg;
    logic [DW-1:0]            g_best_reg;
    logic                     g_func_reg;
    rvec_t                    g_r_reg;
    logic signed [P_W-1:0]    g_p_reg [3];
    logic signed [BND_W-1:0]  g_lo_reg [3];
    logic signed [BND_W-1:0]  g_hi_reg [3];
    logic signed [TD_W-1:0]   td_rnd [3];
    logic signed [BND_W-1:0]  hm [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            td_rnd[i] = (f_td_reg[i] + TD_W'(1 << (FB - 1))) >>> FB;
            hm[i]     = BND_W'($signed(f_side_reg.h[i])) + BND_W'({1'b0, margin_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_vld_reg <= 1'b0;
        end else if (en) begin
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            g_hitpre_reg <= f_hitpre_reg;
            g_t_reg      <= f_t_reg;
            g_best_reg   <= f_side_reg.best;
            g_func_reg   <= f_side_reg.func;
            g_r_reg      <= f_side_reg.r;
            for (int i = 0; i < 3; i++) begin
                g_p_reg[i]  <= P_W'($signed(td_rnd[i][TD_W-FB-1:0]))
                             + P_W'($signed(f_side_reg.s[i]));
                g_lo_reg[i] <= BND_W'($signed(f_side_reg.c[i])) - hm[i];
                g_hi_reg[i] <= BND_W'($signed(f_side_reg.c[i])) + hm[i];
            end
        end
    end

    // box test and result fields ahead of normalization
    logic   inbox;
    nside_t h_side;

    always_comb begin
        inbox = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (g_p_reg[i] < P_W'(g_lo_reg[i]) || g_p_reg[i] > P_W'(g_hi_reg[i])) begin
                inbox = 1'b0;
            end
        end
        h_side.hit   = g_hitpre_reg && inbox;
        h_side.refl  = h_side.hit && g_func_reg;
        h_side.bdist = h_side.hit ? g_t_reg : g_best_reg;
        for (int i = 0; i < 3; i++) begin
            h_side.p[i] = h_side.hit ? sat_comp(g_p_reg[i]) : '0;
        end
    end

    logic   nm_vld;
    vec_t   nm_dir;
    nside_t nm_side;

    rphr_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (g_vld_reg),
        .r        (g_r_reg),
        .side_in  (h_side),
        .vld_out  (nm_vld),
        .dir      (nm_dir),
        .side_out (nm_side)
    );

    // output register
    logic [OUT_TDATA_W-1:0] data_next;

    always_comb begin
        data_next = '0;
        data_next[0 +: DW]          = nm_side.bdist;
        data_next[OFS_NSTART +: VW] = nm_side.p;
        data_next[OFS_NDIR +: VW]   = nm_side.hit ? nm_dir : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= nm_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= data_next;
            m_user_reg <= {nm_side.refl, nm_side.hit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // reflection flag only on a hit
    a_refl_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("reflected without hit");

    // a miss carries no point and no direction
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[OFS_NSTART +: 2*VW] == '0)
        else $error("miss with nonzero point or direction");

    // a hit is strictly nearer than the largest distance
    a_hit_near: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[DW-1:0] != '1)
        else $error("hit at maximum distance");

endmodule
`default_nettype wire

@@ tb/ray_plane_hit_reflect_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_plane_hit_reflect_unit_tb
// Streams ray / plane pairs through the hit unit and checks every result
// against a built-in fixed point predictor of the hit test, hit point and
// normalized reflection, with random idling on both sides and margin changes.
// ----------------------------------------------------------------------------
module ray_plane_hit_reflect_unit_tb;
    import rphr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam longint C_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint C_MIN = -(64'sd1 <<< (CW - 1));

    typedef struct {
        logic          hit;
        logic [DW-1:0] bdist;
        logic [VW-1:0] pnt;
        logic [VW-1:0] dir;
        logic          refl;
    } hit_res_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [MW-1:0] cfg_wr_data = '0;

    hit_res_t expected_hits[$];
    logic [MW-1:0] margin = MARGIN_RST;
    int errors = 0;
    int sent = 0;
    int got = 0;
    int hits_seen = 0;
    int idle_cycles = 0;
    bit timed_out = 0;

    ray_plane_hit_reflect_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic longint comp(logic [VW-1:0] v, int i);
        logic signed [CW-1:0] c;
        c = v[i*CW +: CW];
        return longint'(c);
    endfunction

    function automatic longint clamp(longint v);
        return v > C_MAX ? C_MAX : (v < C_MIN ? C_MIN : v);
    endfunction

    function automatic longint rnd_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic hit_res_t predict_hit(logic fn, logic [IN_TDATA_W-1:0] td,
                                             logic [MW-1:0] mg);
        hit_res_t res;
        longint s[3], d[3], n[3], c[3], h[3], p[3], r[3], nd[3];
        longint unsigned mag[3], maxm, sum, len;
        longint d1, d2, sdist, t, k, off, best, mgl;
        logic signed [CW-1:0] offc;
        bit ok;
        d1 = 0;
        d2 = 0;
        mgl = 0;
        mgl[MW-1:0] = mg;
        for (int i = 0; i < 3; i++) begin
            s[i] = comp(td[OFS_START +: VW], i);
            d[i] = comp(td[OFS_DIR +: VW], i);
            n[i] = comp(td[OFS_NORMAL +: VW], i);
            c[i] = comp(td[OFS_CENTER +: VW], i);
            h[i] = comp(td[OFS_HALF +: VW], i);
            d1 += n[i] * d[i];
            d2 += n[i] * s[i];
        end
        offc = td[OFS_OFFSET +: CW];
        off = longint'(offc);
        best = longint'({33'd0, td[OFS_BEST +: DW]});
        sdist = d2 - (off <<< FB);
        ok = 1;
        t = 0;
        if (d1 > -EPS_Q || sdist < 0) begin
            ok = 0;
        end else begin
            t = (sdist <<< FB) / (-d1);
            if (t >= best) ok = 0;
        end
        if (ok) begin
            for (int i = 0; i < 3; i++) begin
                p[i] = s[i] + rnd_shift(t * d[i], FB);
                if (p[i] < c[i] - (h[i] + mgl) || p[i] > c[i] + (h[i] + mgl)) ok = 0;
            end
        end
        res.hit = ok;
        res.refl = ok ? fn : 1'b0;
        res.pnt = '0;
        res.dir = '0;
        res.bdist = ok ? DW'(t) : DW'(best);
        if (!ok) return res;
        k = rnd_shift(-d1, FB);
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            r[i] = d[i] + rnd_shift(2 * k * n[i], FB);
            mag[i] = r[i] < 0 ? -r[i] : r[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        if (maxm == 0) begin
            nd = '{0, 0, 0};
        end else begin
            while (maxm >= (64'd1 << 30)) begin
                maxm >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (maxm < (64'd1 << 29)) begin
                maxm <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++) begin
                nd[i] = longint'(((mag[i] << FB) + len / 2) / len);
                if (r[i] < 0) nd[i] = -nd[i];
            end
        end
        for (int i = 0; i < 3; i++) begin
            res.pnt[i*CW +: CW] = CW'(clamp(p[i]));
            res.dir[i*CW +: CW] = CW'(clamp(nd[i]));
        end
        return res;
    endfunction

    task automatic send_ray(logic fn, logic [IN_TDATA_W-1:0] td);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        td[IN_TDATA_W-1:IN_RAW_W] = '0;
        s_tvalid <= 1'b1;
        s_tdata <= td;
        s_tuser <= fn;
        expected_hits.push_back(predict_hit(fn, td, margin));
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic write_margin(logic [MW-1:0] v);
        s_tvalid <= 1'b0;
        wait (expected_hits.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        margin = v;
    endtask

    function automatic logic [VW-1:0] vec3(longint x, longint y, longint z);
        return {CW'(z), CW'(y), CW'(x)};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_ray(
        logic [VW-1:0] st, logic [VW-1:0] dr, logic [VW-1:0] nm, longint off,
        logic [VW-1:0] ctr, logic [VW-1:0] hf, logic [DW-1:0] best);
        logic [IN_TDATA_W-1:0] td;
        td = '0;
        td[OFS_START +: VW] = st;
        td[OFS_DIR +: VW] = dr;
        td[OFS_NORMAL +: VW] = nm;
        td[OFS_OFFSET +: CW] = CW'(off);
        td[OFS_CENTER +: VW] = ctr;
        td[OFS_HALF +: VW] = hf;
        td[OFS_BEST +: DW] = best;
        return td;
    endfunction

    function automatic longint rcomp(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // mostly well-formed geometry that faces the ray, with random scale
    function automatic logic [IN_TDATA_W-1:0] random_ray();
        int ax, sc;
        longint n[3], s[3], d[3], off;
        logic [VW-1:0] ctr, hf;
        logic [IN_TDATA_W-1:0] td;
        if ($urandom_range(0, 9) == 0) begin
            for (int i = 0; i < IN_TDATA_W; i += 32) td[i +: 32] = $urandom();
            return td;
        end
        ax = $urandom_range(0, 2);
        sc = $urandom_range(2, 18);
        for (int i = 0; i < 3; i++) begin
            n[i] = rcomp(200);
            s[i] = rcomp(1 << sc);
            d[i] = rcomp(1024);
        end
        n[ax] = ($urandom_range(0, 1) ? 1024 : -1024) + rcomp(40);
        d[ax] = -(n[ax] > 0 ? 1 : -1) * longint'($urandom_range(0, 1500));
        off = rcomp(1 << sc);
        ctr = vec3(rcomp(1 << sc), rcomp(1 << sc), rcomp(1 << sc));
        hf = vec3($urandom_range(0, 1 << sc), $urandom_range(0, 1 << sc),
                  $urandom_range(0, 1 << sc));
        if ($urandom_range(0, 5) == 0) hf = VW'({$urandom(), $urandom()});
        return pack_ray(vec3(s[0], s[1], s[2]), vec3(d[0], d[1], d[2]),
                        vec3(n[0], n[1], n[2]), off, ctr, hf,
                        $urandom_range(0, 3) == 0 ? DW'($urandom()) : {DW{1'b1}});
    endfunction

    task automatic test_directed();
        logic [VW-1:0] big, nz;
        big = vec3(C_MAX, C_MAX, C_MAX);
        nz = vec3(0, 0, 1024);
        // plain hit and mirror hit on z = 0 plane facing up
        send_ray(1'b0, pack_ray(vec3(0, 0, 5120), vec3(0, 0, -1024), nz, 0, '0,
                                vec3(2048, 2048, 2048), {DW{1'b1}}));
        send_ray(1'b1, pack_ray(vec3(300, -200, 5120), vec3(512, 0, -1024), nz, 0, '0,
                                big, {DW{1'b1}}));
        // back facing and parallel
        send_ray(1'b0, pack_ray(vec3(0, 0, 5120), vec3(0, 0, 1024), nz, 0, '0, big,
                                {DW{1'b1}}));
        send_ray(1'b1, pack_ray(vec3(0, 0, 5120), vec3(1024, 0, 0), nz, 0, '0, big,
                                {DW{1'b1}}));
        // start behind the plane
        send_ray(1'b0, pack_ray(vec3(0, 0, -5120), vec3(0, 0, -1024), nz, 0, '0, big,
                                {DW{1'b1}}));
        // nearer test: best equals t, then best just above t, then best zero
        send_ray(1'b0, pack_ray(vec3(0, 0, 5120), vec3(0, 0, -1024), nz, 0, '0, big,
                                DW'(5120)));
        send_ray(1'b1, pack_ray(vec3(0, 0, 5120), vec3(0, 0, -1024), nz, 0, '0, big,
                                DW'(5121)));
        send_ray(1'b0, pack_ray(vec3(0, 0, 5120), vec3(0, 0, -1024), nz, 0, '0, big, '0));
        // box edge with margin, just inside and just outside, and empty box
        send_ray(1'b0, pack_ray(vec3(1126, 0, 5120), vec3(0, 0, -1024), nz, 0, '0,
                                vec3(1024, 1024, 0), {DW{1'b1}}));
        send_ray(1'b0, pack_ray(vec3(1127, 0, 5120), vec3(0, 0, -1024), nz, 0, '0,
                                vec3(1024, 1024, 0), {DW{1'b1}}));
        send_ray(1'b1, pack_ray(vec3(0, 0, 5120), vec3(0, 0, -1024), nz, 0, '0,
                                vec3(-2000, -2000, -2000), {DW{1'b1}}));
        // half-length normal: r = (0, 0, -512), which normalizes to (0, 0, -1024)
        send_ray(1'b1, pack_ray(vec3(0, 0, 2048), vec3(0, 0, -1024), vec3(0, 0, 512), 0,
                                '0, big, {DW{1'b1}}));
        // extremes: saturated hit point, long distance, field extremes
        send_ray(1'b0, pack_ray(vec3(C_MAX, C_MIN, C_MAX), vec3(C_MIN, C_MAX, C_MIN),
                                vec3(C_MAX, 0, C_MAX), C_MIN, '0, big, {DW{1'b1}}));
        send_ray(1'b1, pack_ray(vec3(0, 0, C_MAX), vec3(0, 0, -1), vec3(0, 0, 1024), C_MIN,
                                '0, big, {DW{1'b1}}));
        send_ray(1'b1, pack_ray(vec3(C_MIN, C_MIN, C_MIN), vec3(C_MIN, C_MIN, C_MIN),
                                vec3(C_MIN, C_MIN, C_MIN), C_MAX, big, big, {DW{1'b1}}));
        send_ray(1'b0, {IN_TDATA_W{1'b1}});
        send_ray(1'b1, '0);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++) send_ray($urandom_range(0, 1), random_ray());
    endtask

    task automatic test_margins();
        write_margin('0);
        send_ray(1'b0, pack_ray(vec3(1025, 0, 5120), vec3(0, 0, -1024), vec3(0, 0, 1024),
                                0, '0, vec3(1024, 1024, 0), {DW{1'b1}}));
        test_random(100);
        write_margin({MW{1'b1}});
        send_ray(1'b1, pack_ray(vec3(2047, 0, 5120), vec3(0, 0, -1024), vec3(0, 0, 1024),
                                0, '0, vec3(1024, 1024, 0), {DW{1'b1}}));
        test_random(100);
        write_margin(MW'($urandom_range(0, 1023)));
        test_random(100);
    endtask

    // result side: random stalls and field checks
    always @(posedge aclk) begin
        hit_res_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got++;
                if (expected_hits.size() == 0) begin
                    $error("result transfer with nothing expected");
                    errors++;
                end else begin
                    e = expected_hits.pop_front();
                    if (e.hit) hits_seen++;
                    if (m_tuser[0] !== e.hit) begin
                        $error("hit: expected %0h actual %0h", e.hit, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== e.refl) begin
                        $error("reflected: expected %0h actual %0h", e.refl, m_tuser[1]);
                        errors++;
                    end
                    if (m_tdata[0 +: DW] !== e.bdist) begin
                        $error("best_distance_out: expected %0h actual %0h", e.bdist,
                               m_tdata[0 +: DW]);
                        errors++;
                    end
                    if (m_tdata[OFS_NSTART +: VW] !== e.pnt) begin
                        $error("next_start: expected %0h actual %0h", e.pnt,
                               m_tdata[OFS_NSTART +: VW]);
                        errors++;
                    end
                    if (m_tdata[OFS_NDIR +: VW] !== e.dir) begin
                        $error("next_dir: expected %0h actual %0h", e.dir,
                               m_tdata[OFS_NDIR +: VW]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 2) == 0) ? 1'b1 : ($urandom_range(0, 14) < 3);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en ||
            expected_hits.size() == 0) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        fork
            begin
                test_directed();
                test_random(150);
                test_margins();
                write_margin(MARGIN_RST);
                test_random(20);
                s_tvalid <= 1'b0;
                wait (expected_hits.size() == 0);
                repeat (DRAIN_CYCLES) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1;
            end
        join_any
        if (timed_out) begin
            $display("watchdog expired with %0d results outstanding", expected_hits.size());
            $display("end of test: mismatches");
        end else begin
            $display("sent %0d rays, checked %0d results, %0d hits, margins 0/1023/random",
                     sent, got, hits_seen);
            if (errors == 0) begin
                $display("end of test: clean");
            end else begin
                $display("end of test: mismatches");
            end
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rphr_pkg.sv
rtl/core/rphr_tdiv.sv
rtl/core/rphr_norm.sv
rtl/core/ray_plane_hit_reflect_unit.sv
tb/ray_plane_hit_reflect_unit_tb.sv
